// ----- rtl/assert_macros.svh -----
// Assertion shorthands for the polar converter RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while in reset.
`define ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication, quiet while in reset.
`define ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ----- rtl/c2pq_pkg.sv -----
// Shared types, codes and the arctangent table of the polar converter.
// No dependencies.
package c2pq_pkg;

    localparam int QUAD_W   = 3;
    localparam int RADIUS_W = 16;
    localparam int ZW       = 34;   // signed angle accumulator, 2^-32 turn units
    localparam int CXW      = 64;   // signed vector datapath
    localparam int FULL_W   = 33;   // unsigned full-circle angle, 2^-32 turn units

    localparam logic [QUAD_W-1:0] QC_ORIGIN = 3'd0;
    localparam logic [QUAD_W-1:0] QC_Q1     = 3'd1;
    localparam logic [QUAD_W-1:0] QC_Q2     = 3'd2;
    localparam logic [QUAD_W-1:0] QC_Q3     = 3'd3;
    localparam logic [QUAD_W-1:0] QC_Q4     = 3'd4;
    localparam logic [QUAD_W-1:0] QC_YAXIS  = 3'd5;
    localparam logic [QUAD_W-1:0] QC_XAXIS  = 3'd6;

    // 90 degrees in 2^-32 turn units
    localparam logic [FULL_W-1:0] QUARTER_TURN = 33'h0_4000_0000;

    typedef struct packed {
        logic              xneg;
        logic              yneg;
        logic [QUAD_W-1:0] code;
    } t_ctl;

    // atan(2^-i) in 2^-32 turn units
    function automatic logic [31:0] f_atan(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/c2pq_prep.sv -----
// Front end: magnitudes, position code, squares and their sum, three stages.
// Depends on c2pq_pkg.
module c2pq_prep
    import c2pq_pkg::*;
#(
    parameter int CW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  logic signed [CW-1:0]  i_x,
    input  logic signed [CW-1:0]  i_y,
    output logic                  o_valid,
    output t_ctl                  o_ctl,
    output logic [2*CW-1:0]       o_sum,
    output logic signed [CXW-1:0] o_cx,
    output logic signed [CXW-1:0] o_cy
);
    localparam int SQW   = 2 * CW;
    localparam int SHIFT = 60 - CW;

    logic          r_va, r_vb, r_vc;
    t_ctl          r_ctl_a, r_ctl_b, r_ctl_c;
    logic [CW-1:0] r_ax_a, r_ay_a, r_ax_b, r_ay_b, r_ax_c, r_ay_c;
    logic [SQW-1:0] r_sqx, r_sqy, r_sum;

    logic          xneg, yneg, xzero, yzero;
    logic [CW-1:0] n_ax, n_ay;
    t_ctl          n_ctl;

    always_comb begin
        xneg  = i_x[CW-1];
        yneg  = i_y[CW-1];
        xzero = (i_x == '0);
        yzero = (i_y == '0);
        // the most negative value wraps to its own magnitude as unsigned
        n_ax  = xneg ? CW'(-i_x) : i_x;
        n_ay  = yneg ? CW'(-i_y) : i_y;
        n_ctl.xneg = xneg;
        n_ctl.yneg = yneg;
        if (xzero && yzero) begin
            n_ctl.code = QC_ORIGIN;
        end else if (xzero) begin
            n_ctl.code = QC_YAXIS;
        end else if (yzero) begin
            n_ctl.code = QC_XAXIS;
        end else if (!xneg && !yneg) begin
            n_ctl.code = QC_Q1;
        end else if (xneg && !yneg) begin
            n_ctl.code = QC_Q2;
        end else if (xneg && yneg) begin
            n_ctl.code = QC_Q3;
        end else begin
            n_ctl.code = QC_Q4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_adv) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ax_a  <= n_ax;
            r_ay_a  <= n_ay;
            r_ctl_a <= n_ctl;
            r_sqx   <= SQW'(r_ax_a) * SQW'(r_ax_a);
            r_sqy   <= SQW'(r_ay_a) * SQW'(r_ay_a);
            r_ax_b  <= r_ax_a;
            r_ay_b  <= r_ay_a;
            r_ctl_b <= r_ctl_a;
            r_sum   <= r_sqx + r_sqy;
            r_ax_c  <= r_ax_b;
            r_ay_c  <= r_ay_b;
            r_ctl_c <= r_ctl_b;
        end
    end

    assign o_valid = r_vc;
    assign o_ctl   = r_ctl_c;
    assign o_sum   = r_sum;
    assign o_cx    = CXW'(r_ax_c) << SHIFT;
    assign o_cy    = CXW'(r_ay_c) << SHIFT;

endmodule

// ----- rtl/c2pq_step.sv -----
// One core stage: one root bit of the square root and one vectoring rotation.
// Depends on c2pq_pkg.
module c2pq_step
    import c2pq_pkg::*;
#(
    parameter int CW  = 16,
    parameter int RS  = 16,
    parameter int IDX = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  t_ctl                  i_ctl,
    input  logic [2*CW-1:0]       i_rem,
    input  logic [2*CW-1:0]       i_root,
    input  logic signed [CXW-1:0] i_cx,
    input  logic signed [CXW-1:0] i_cy,
    input  logic signed [ZW-1:0]  i_z,
    output logic                  o_valid,
    output t_ctl                  o_ctl,
    output logic [2*CW-1:0]       o_rem,
    output logic [2*CW-1:0]       o_root,
    output logic signed [CXW-1:0] o_cx,
    output logic signed [CXW-1:0] o_cy,
    output logic signed [ZW-1:0]  o_z
);
    localparam int SQW = 2 * CW;
    localparam int J   = (IDX < CW) ? (CW - 1 - IDX) : 0;
    localparam logic [SQW-1:0] SQ_BIT = SQW'(1) << (2 * J);

    logic                  r_valid;
    t_ctl                  r_ctl;
    logic [SQW-1:0]        r_rem, r_root;
    logic signed [CXW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0]  r_z;

    logic [SQW-1:0]        trial, n_rem, n_root;
    logic signed [CXW-1:0] sx, sy, n_cx, n_cy;
    logic signed [ZW-1:0]  atan_z, n_z;

    always_comb begin
        trial  = i_root + SQ_BIT;
        n_rem  = i_rem;
        n_root = i_root;
        if (IDX < CW) begin
            if (i_rem >= trial) begin
                n_rem  = i_rem - trial;
                n_root = (i_root >> 1) + SQ_BIT;
            end else begin
                n_root = i_root >> 1;
            end
        end
    end

    always_comb begin
        sx     = i_cx >>> IDX;
        sy     = i_cy >>> IDX;
        atan_z = $signed({2'b00, f_atan(IDX)});
        n_cx   = i_cx;
        n_cy   = i_cy;
        n_z    = i_z;
        if (IDX < RS) begin
            // rotate toward the x axis
            if (!i_cy[CXW-1] && (i_cy != '0)) begin
                n_cx = i_cx + sy;
                n_cy = i_cy - sx;
                n_z  = i_z + atan_z;
            end else begin
                n_cx = i_cx - sy;
                n_cy = i_cy + sx;
                n_z  = i_z - atan_z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctl  <= i_ctl;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_z    <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_cx    = r_cx;
    assign o_cy    = r_cy;
    assign o_z     = r_z;

endmodule

// ----- rtl/c2pq_post.sv -----
// Back end: clamp and fold the angle, round it, saturate the radius; output register.
// Depends on c2pq_pkg.
module c2pq_post
    import c2pq_pkg::*;
#(
    parameter int CW = 16,
    parameter int AW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  t_ctl                 i_ctl,
    input  logic [2*CW-1:0]      i_root,
    input  logic signed [ZW-1:0] i_z,
    output logic                 o_valid,
    output logic [RADIUS_W-1:0]  o_radius,
    output logic [AW-1:0]        o_angle,
    output logic [QUAD_W-1:0]    o_quadrant
);
    localparam int SQW = 2 * CW;
    localparam logic [SQW-1:0]    RMAX  = SQW'({RADIUS_W{1'b1}});
    localparam logic [FULL_W:0]   ROUND = (FULL_W + 1)'(1) << (31 - AW);
    localparam logic signed [ZW-1:0] ZQ = $signed(ZW'(QUARTER_TURN));

    logic                r_valid;
    logic [RADIUS_W-1:0] r_radius;
    logic [AW-1:0]       r_angle;
    logic [QUAD_W-1:0]   r_quad;

    logic [FULL_W-1:0]   q, full;
    logic [FULL_W:0]     rounded;
    logic [RADIUS_W-1:0] n_radius;

    always_comb begin
        if (i_z[ZW-1]) begin
            q = '0;
        end else if (i_z > ZQ) begin
            q = QUARTER_TURN;
        end else begin
            q = FULL_W'(i_z);
        end
        case (i_ctl.code)
            QC_ORIGIN: full = '0;
            QC_YAXIS:  full = i_ctl.yneg ? FULL_W'(3 * QUARTER_TURN) : QUARTER_TURN;
            QC_XAXIS:  full = i_ctl.xneg ? FULL_W'(2 * QUARTER_TURN) : '0;
            QC_Q1:     full = q;
            QC_Q2:     full = FULL_W'(2 * QUARTER_TURN) - q;
            QC_Q3:     full = FULL_W'(2 * QUARTER_TURN) + q;
            QC_Q4:     full = FULL_W'(4 * QUARTER_TURN) - q;
            default:   full = '0;
        endcase
        // round to nearest; a full turn wraps to zero by dropping bit 32
        rounded  = {1'b0, full} + ROUND;
        n_radius = (i_root > RMAX) ? {RADIUS_W{1'b1}} : i_root[RADIUS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_radius <= n_radius;
            r_angle  <= rounded[32-AW +: AW];
            r_quad   <= i_ctl.code;
        end
    end

    assign o_valid    = r_valid;
    assign o_radius   = r_radius;
    assign o_angle    = r_angle;
    assign o_quadrant = r_quad;

endmodule

// ----- rtl/cartesian_to_polar_quadrant_core.sv -----
// Channel  | handshake          | word
// ---------+--------------------+------------------------------------------
// input    | i_valid / o_stall  | i_x_coord, i_y_coord (signed)
// output   | o_valid / i_stall  | o_radius, o_angle, o_quadrant
//
// One word in per cycle while o_stall is low, one word out per word in, in order.
// Stages, in order: three front-end stages (magnitudes, squares, sum),
// one core stage per root bit / rotation, one output stage.
// The whole pipeline advances as one; it holds only while a result sits in the
// output register and i_stall is high, and o_stall reflects exactly that.
// Synchronous active-low reset clears the valid bits; data registers are not reset.
`include "assert_macros.svh"

module cartesian_to_polar_quadrant_core
    import c2pq_pkg::*;
#(
    parameter int COORD_WIDTH    = 16,
    parameter int ANGLE_WIDTH    = 16,
    parameter int ROTATION_STEPS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_x_coord,
    input  logic signed [COORD_WIDTH-1:0] i_y_coord,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [RADIUS_W-1:0]           o_radius,
    output logic [ANGLE_WIDTH-1:0]        o_angle,
    output logic [QUAD_W-1:0]             o_quadrant
);
    localparam int SQW = 2 * COORD_WIDTH;
    // core depth: enough stages for every root bit and every rotation
    localparam int NST = (COORD_WIDTH > ROTATION_STEPS) ? COORD_WIDTH : ROTATION_STEPS;
    // half a turn at the output angle width
    localparam logic [ANGLE_WIDTH-1:0] HALF_ANG = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};

    logic adv;

    logic                  w_valid [0:NST];
    t_ctl                  w_ctl   [0:NST];
    logic [SQW-1:0]        w_rem   [0:NST];
    logic [SQW-1:0]        w_root  [0:NST];
    logic signed [CXW-1:0] w_cx    [0:NST];
    logic signed [CXW-1:0] w_cy    [0:NST];
    logic signed [ZW-1:0]  w_z     [0:NST];

    // advance everything unless a finished word is held at the output
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    c2pq_prep #(
        .CW (COORD_WIDTH)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_valid),
        .i_x     (i_x_coord),
        .i_y     (i_y_coord),
        .o_valid (w_valid[0]),
        .o_ctl   (w_ctl[0]),
        .o_sum   (w_rem[0]),
        .o_cx    (w_cx[0]),
        .o_cy    (w_cy[0])
    );

    // root starts at zero, angle accumulator at zero
    assign w_root[0] = '0;
    assign w_z[0]    = '0;

    for (genvar s = 0; s < NST; s++) begin : g_core
        c2pq_step #(
            .CW  (COORD_WIDTH),
            .RS  (ROTATION_STEPS),
            .IDX (s)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (w_valid[s]),
            .i_ctl   (w_ctl[s]),
            .i_rem   (w_rem[s]),
            .i_root  (w_root[s]),
            .i_cx    (w_cx[s]),
            .i_cy    (w_cy[s]),
            .i_z     (w_z[s]),
            .o_valid (w_valid[s+1]),
            .o_ctl   (w_ctl[s+1]),
            .o_rem   (w_rem[s+1]),
            .o_root  (w_root[s+1]),
            .o_cx    (w_cx[s+1]),
            .o_cy    (w_cy[s+1]),
            .o_z     (w_z[s+1])
        );
    end

    c2pq_post #(
        .CW (COORD_WIDTH),
        .AW (ANGLE_WIDTH)
    ) u_post (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_valid    (w_valid[NST]),
        .i_ctl      (w_ctl[NST]),
        .i_root     (w_root[NST]),
        .i_z        (w_z[NST]),
        .o_valid    (o_valid),
        .o_radius   (o_radius),
        .o_angle    (o_angle),
        .o_quadrant (o_quadrant)
    );

    // the origin maps to zero radius and zero angle
    `ASSERT_NOW(a_origin, o_valid && (o_quadrant == QC_ORIGIN), (o_radius | o_angle) == '0)
    // any other point has a nonzero radius
    `ASSERT_NOW(a_radius_nz, o_valid && (o_quadrant != QC_ORIGIN), o_radius != '0)
    // on the x axis the angle is exactly zero or a half turn
    `ASSERT_NOW(a_xaxis, o_valid && (o_quadrant == QC_XAXIS), (o_angle & ~HALF_ANG) == '0)
    // a held output word keeps the whole pipeline frozen, so nothing new enters
    `ASSERT_NEXT(a_hold, o_valid && i_stall, o_valid)

endmodule

// ----- test/cartesian_to_polar_quadrant_core_tb.sv -----
// Self-checking testbench for cartesian_to_polar_quadrant_core: radius, angle and quadrant code.
// Depends on c2pq_pkg for the quadrant codes and result widths, and on cartesian_to_polar_quadrant_core.
// Drives directed and random points under several idle/stall mixes and checks every result word.
module cartesian_to_polar_quadrant_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import c2pq_pkg::*;

    localparam int XY_W       = 16;
    localparam int ANG_W      = 16;
    localparam int ROTATIONS  = 16;
    localparam int LATENCY    = 4 + ROTATIONS;
    // Fixed-point scale of the rotation datapath: coordinates sit at 2^(60 - XY_W).
    localparam int VEC_SHIFT  = 60 - XY_W;
    localparam longint TURN_QUARTER = 64'h4000_0000;   // 90 degrees in 2^-32 turn units

    // atan(2^-i) in 2^-32 turn units, one entry per rotation
    localparam longint ARCTAN_STEP [0:ROTATIONS-1] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    typedef struct {
        logic [RADIUS_W-1:0] radius;
        logic [ANG_W-1:0]    angle;
        logic [QUAD_W-1:0]   quadrant;
    } t_polar_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic signed [XY_W-1:0] i_x_coord;
    logic signed [XY_W-1:0] i_y_coord;
    logic                   o_valid;
    logic                   i_stall;
    logic [RADIUS_W-1:0]    o_radius;
    logic [ANG_W-1:0]       o_angle;
    logic [QUAD_W-1:0]      o_quadrant;

    t_polar_word pending_polar[$];
    int          mismatch_count = 0;
    int          point_idle_pct = 0;   // chance per cycle that the sender holds back a word
    int          result_stall_pct = 0; // chance per cycle that the receiver stalls

    cartesian_to_polar_quadrant_core #(
        .COORD_WIDTH    (XY_W),
        .ANGLE_WIDTH    (ANG_W),
        .ROTATION_STEPS (ROTATIONS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_x_coord  (i_x_coord),
        .i_y_coord  (i_y_coord),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_radius   (o_radius),
        .o_angle    (o_angle),
        .o_quadrant (o_quadrant)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Largest r with r*r <= n, built one bit at a time from the top.
    function automatic int unsigned floor_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int k = RADIUS_W - 1; k >= 0; k--) begin
            trial = root | (64'd1 << k);
            if (trial * trial <= n)
                root = trial;
        end
        return int'(root);
    endfunction

    // First-quadrant angle of (mag_x, mag_y), both nonzero, in 2^-32 turn units.
    // Drive the vector onto the x axis and sum the rotations taken.
    function automatic longint first_quadrant_angle(input longint mag_x, input longint mag_y);
        longint vx;
        longint vy;
        longint nx;
        longint ny;
        longint acc;
        vx  = mag_x <<< VEC_SHIFT;
        vy  = mag_y <<< VEC_SHIFT;
        acc = 0;
        for (int i = 0; i < ROTATIONS; i++) begin
            if (vy > 0) begin
                nx  = vx + (vy >>> i);
                ny  = vy - (vx >>> i);
                acc = acc + ARCTAN_STEP[i];
            end else begin
                nx  = vx - (vy >>> i);
                ny  = vy + (vx >>> i);
                acc = acc - ARCTAN_STEP[i];
            end
            vx = nx;
            vy = ny;
        end
        if (acc < 0)
            acc = 0;
        if (acc > TURN_QUARTER)
            acc = TURN_QUARTER;
        return acc;
    endfunction

    function automatic t_polar_word polar_of(input logic signed [XY_W-1:0] x,
                                             input logic signed [XY_W-1:0] y);
        t_polar_word p;
        longint      mag_x;
        longint      mag_y;
        longint      turn_frac;   // full-circle angle, 2^-32 turn units
        longint      q;
        int unsigned root;
        mag_x = (x < 0) ? -longint'(x) : longint'(x);
        mag_y = (y < 0) ? -longint'(y) : longint'(y);

        root = floor_sqrt(longint'(mag_x * mag_x + mag_y * mag_y));
        p.radius = (root > 32'hFFFF) ? '1 : root[RADIUS_W-1:0];

        if (mag_x == 0 && mag_y == 0) begin
            p.quadrant = QC_ORIGIN;
            turn_frac  = 0;
        end else if (mag_x == 0) begin
            p.quadrant = QC_YAXIS;
            turn_frac  = (y < 0) ? 3 * TURN_QUARTER : TURN_QUARTER;
        end else if (mag_y == 0) begin
            p.quadrant = QC_XAXIS;
            turn_frac  = (x < 0) ? 2 * TURN_QUARTER : 0;
        end else begin
            q = first_quadrant_angle(mag_x, mag_y);
            if (x > 0 && y > 0) begin
                p.quadrant = QC_Q1;
                turn_frac  = q;
            end else if (x < 0 && y > 0) begin
                p.quadrant = QC_Q2;
                turn_frac  = 2 * TURN_QUARTER - q;
            end else if (x < 0 && y < 0) begin
                p.quadrant = QC_Q3;
                turn_frac  = 2 * TURN_QUARTER + q;
            end else begin
                p.quadrant = QC_Q4;
                turn_frac  = 4 * TURN_QUARTER - q;
            end
        end

        // Round to nearest unit; a full turn wraps to 0 through the truncation.
        turn_frac = (turn_frac + (64'd1 << (31 - ANG_W))) >>> (32 - ANG_W);
        p.angle   = turn_frac[ANG_W-1:0];
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Send one point word: idle at random first, then hold the word until the
    // block takes it. Record the expected polar word at acceptance.
    task automatic send_point(input logic signed [XY_W-1:0] x, input logic signed [XY_W-1:0] y);
        while ($urandom_range(99) < point_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_x_coord <= x;
        i_y_coord <= y;
        @(posedge i_clk);
        // o_stall read here is its value just before this edge: the one that decided acceptance.
        while (o_stall !== 1'b0)
            @(posedge i_clk);
        pending_polar.push_back(polar_of(x, y));
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall and the result check
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < result_stall_pct);
    end

    always @(posedge i_clk) begin
        t_polar_word want;
        logic [ANG_W-1:0] ang_diff;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_polar.size() == 0) begin
                $error("result word with no point outstanding: radius %0d angle %0d quadrant %0d",
                       o_radius, o_angle, o_quadrant);
                mismatch_count++;
            end else begin
                want = pending_polar.pop_front();
                if (o_radius !== want.radius) begin
                    $error("radius: expected %0d, actual %0d", want.radius, o_radius);
                    mismatch_count++;
                end
                // The angle may land one unit off either way, wrapping around the full turn.
                ang_diff = o_angle - want.angle;
                if ($isunknown(o_angle) || !(ang_diff == 0 || ang_diff == 1 || ang_diff == '1))
                begin
                    $error("angle: expected %0d, actual %0d", want.angle, o_angle);
                    mismatch_count++;
                end
                if (o_quadrant !== want.quadrant) begin
                    $error("quadrant: expected %0d, actual %0d", want.quadrant, o_quadrant);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Origin and all four half-axes, at unit and full-scale distance.
    task automatic test_origin_and_axes();
        send_point(16'sd0, 16'sd0);
        send_point(16'sd1, 16'sd0);
        send_point(-16'sd1, 16'sd0);
        send_point(16'sd0, 16'sd1);
        send_point(16'sd0, -16'sd1);
        send_point(16'sd32767, 16'sd0);
        send_point(-16'sd32768, 16'sd0);
        send_point(16'sd0, 16'sd32767);
        send_point(16'sd0, -16'sd32768);
    endtask

    // Field extremes in every quadrant, including the largest radius.
    task automatic test_extremes();
        send_point(16'sd32767, 16'sd32767);
        send_point(-16'sd32768, 16'sd32767);
        send_point(-16'sd32768, -16'sd32768);
        send_point(16'sd32767, -16'sd32768);
        send_point(16'sd1, 16'sd1);
        send_point(-16'sd1, 16'sd1);
        send_point(-16'sd1, -16'sd1);
        send_point(16'sd1, -16'sd1);
    endtask

    // Points hugging the axes: tiny angles, and the fourth-quadrant point whose
    // angle rounds up to a full turn and must wrap to 0.
    task automatic test_near_axes();
        send_point(16'sd32767, 16'sd1);
        send_point(16'sd32767, -16'sd1);
        send_point(-16'sd32768, 16'sd1);
        send_point(-16'sd32768, -16'sd1);
        send_point(16'sd1, 16'sd32767);
        send_point(-16'sd1, -16'sd32768);
    endtask

    // Random points: mostly full range, plus small coordinates that often land
    // on the origin or an axis, plus points pinned close to one axis.
    task automatic random_points(input int count);
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        int                     pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(9);
            x = XY_W'($urandom());
            y = XY_W'($urandom());
            if (pick < 2) begin
                x = XY_W'(int'($urandom_range(6)) - 3);
                y = XY_W'(int'($urandom_range(6)) - 3);
            end else if (pick < 3) begin
                y = XY_W'(int'($urandom_range(8)) - 4);
            end else if (pick < 4) begin
                x = XY_W'(int'($urandom_range(8)) - 4);
            end
            send_point(x, y);
        end
    endtask

    task automatic test_random_streaming();
        point_idle_pct   = 0;
        result_stall_pct = 0;
        random_points(375);
    endtask

    task automatic test_random_sender_idle();
        point_idle_pct   = 59;
        result_stall_pct = 0;
        random_points(375);
    endtask

    task automatic test_random_receiver_stall();
        point_idle_pct   = 0;
        result_stall_pct = 59;
        random_points(375);
    endtask

    task automatic test_random_both_idle();
        point_idle_pct   = 17;
        result_stall_pct = 17;
        random_points(375);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_stall   = 1'b0;
        i_x_coord = '0;
        i_y_coord = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_origin_and_axes();
        test_extremes();
        test_near_axes();
        test_random_streaming();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();

        // Drop valid, release the receiver and drain the pipeline.
        i_valid          <= 1'b0;
        result_stall_pct = 0;
        point_idle_pct   = 0;
        while (pending_polar.size() != 0)
            @(posedge i_clk);
        // Give any stray extra word time to show up.
        repeat (LATENCY + 4) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hang guard: far beyond the slowest legal run of about 1500 words.
    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- cartesian_to_polar_quadrant_core.f -----
+incdir+rtl
rtl/c2pq_pkg.sv
rtl/c2pq_prep.sv
rtl/c2pq_step.sv
rtl/c2pq_post.sv
rtl/cartesian_to_polar_quadrant_core.sv
test/cartesian_to_polar_quadrant_core_tb.sv
